[rtl/core/srt_pkg.sv]
// Shared types, codes and the byte classifier of the S-expression tokenizer.
package srt_pkg;

	// event codes
	localparam logic [2:0] EV_BYTE  = 3'd0;
	localparam logic [2:0] EV_SYM   = 3'd1;
	localparam logic [2:0] EV_NUM   = 3'd2;
	localparam logic [2:0] EV_STR   = 3'd3;
	localparam logic [2:0] EV_OPEN  = 3'd4;
	localparam logic [2:0] EV_CLOSE = 3'd5;
	localparam logic [2:0] EV_END   = 3'd6;
	localparam logic [2:0] EV_ERR   = 3'd7;

	// list kinds
	localparam logic [2:0] K_PAREN   = 3'd0;
	localparam logic [2:0] K_VECTOR  = 3'd1;
	localparam logic [2:0] K_MAP     = 3'd2;
	localparam logic [2:0] K_QUOTE   = 3'd3;
	localparam logic [2:0] K_QUASI   = 3'd4;
	localparam logic [2:0] K_UNQUOTE = 3'd5;

	// error codes
	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_MISMATCH   = 3'd1;
	localparam logic [2:0] ERR_UNMATCHED  = 3'd2;
	localparam logic [2:0] ERR_OPEN_AT_END = 3'd3;
	localparam logic [2:0] ERR_OVERFLOW   = 3'd4;

	// characters
	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_DQUOTE  = 8'h22;
	localparam logic [7:0] CH_SQUOTE  = 8'h27;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_0       = 8'h30;
	localparam logic [7:0] CH_9       = 8'h39;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_LBRACK  = 8'h5B;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_RBRACK  = 8'h5D;
	localparam logic [7:0] CH_BTICK   = 8'h60;
	localparam logic [7:0] CH_LBRACE  = 8'h7B;
	localparam logic [7:0] CH_RBRACE  = 8'h7D;
	localparam logic [7:0] CH_TILDE   = 8'h7E;

	// head classes kept for the number test
	localparam logic [1:0] HC_OTHER = 2'd0;
	localparam logic [1:0] HC_DIGIT = 2'd1;
	localparam logic [1:0] HC_DOT   = 2'd2;
	localparam logic [1:0] HC_SIGN  = 2'd3;

	localparam int unsigned OUT_TDATA_W = 16;

	typedef enum logic [2:0] {
		CLS_OTHER  = 3'd0,
		CLS_END    = 3'd1,
		CLS_OPEN   = 3'd2,
		CLS_CLOSE  = 3'd3,
		CLS_SEMI   = 3'd4,
		CLS_DQUOTE = 3'd5,
		CLS_BSLASH = 3'd6,
		CLS_SEP    = 3'd7
	} cls_t;

	typedef struct packed {
		logic [7:0] text_byte;
		cls_t       cls;
		logic [2:0] kind;
		logic       nl;
		logic [1:0] hc;
	} item_t;

	typedef enum logic [5:0] {
		MODE_SPACE   = 6'b000001,
		MODE_SYMBOL  = 6'b000010,
		MODE_STRING  = 6'b000100,
		MODE_ESCAPE  = 6'b001000,
		MODE_COMMENT = 6'b010000,
		MODE_ERROR   = 6'b100000
	} mode_t;

	typedef enum logic [4:0] {
		ST_DISPATCH = 5'b00001,
		ST_PFX      = 5'b00010,
		ST_OPEN     = 5'b00100,
		ST_CLOSE    = 5'b01000,
		ST_END      = 5'b10000
	} seq_t;

	typedef enum logic [1:0] {
		AFT_NONE  = 2'd0,
		AFT_OPEN  = 2'd1,
		AFT_CLOSE = 2'd2
	} after_t;

	function automatic item_t classify(input logic [7:0] b);
		item_t it;
		it.text_byte = b;
		it.cls       = CLS_OTHER;
		it.kind      = K_PAREN;
		it.nl        = (b == CH_LF) || (b == CH_CR);
		case (b) inside
			[CH_0:CH_9]:       it.hc = HC_DIGIT;
			CH_DOT:            it.hc = HC_DOT;
			CH_PLUS, CH_MINUS: it.hc = HC_SIGN;
			default:           it.hc = HC_OTHER;
		endcase
		case (b) inside
			CH_NUL:    it.cls = CLS_END;
			CH_LPAREN: begin it.cls = CLS_OPEN;  it.kind = K_PAREN;   end
			CH_LBRACK: begin it.cls = CLS_OPEN;  it.kind = K_VECTOR;  end
			CH_LBRACE: begin it.cls = CLS_OPEN;  it.kind = K_MAP;     end
			CH_SQUOTE: begin it.cls = CLS_OPEN;  it.kind = K_QUOTE;   end
			CH_BTICK:  begin it.cls = CLS_OPEN;  it.kind = K_QUASI;   end
			CH_TILDE:  begin it.cls = CLS_OPEN;  it.kind = K_UNQUOTE; end
			CH_RPAREN: begin it.cls = CLS_CLOSE; it.kind = K_PAREN;   end
			CH_RBRACK: begin it.cls = CLS_CLOSE; it.kind = K_VECTOR;  end
			CH_RBRACE: begin it.cls = CLS_CLOSE; it.kind = K_MAP;     end
			CH_SEMI:   it.cls = CLS_SEMI;
			CH_DQUOTE: it.cls = CLS_DQUOTE;
			CH_BSLASH: it.cls = CLS_BSLASH;
			CH_COMMA, CH_SPACE, [CH_TAB:CH_CR]: it.cls = CLS_SEP;
			default:   it.cls = CLS_OTHER;
		endcase
		return it;
	endfunction

endpackage

[rtl/core/sexpr_reader_tokenizer_core.sv]
// Top level of the S-expression tokenizer: front end, item queue, back end.
//
//  channel  dir  signals                      payload
//  s_*      in   s_tvalid s_tready s_tdata    text_byte
//  m_*      out  m_tvalid m_tready m_tdata    event_res, value, error_code; m_tlast = last
//
// A byte passes the front register and the two-entry queue, then the back sequencer.
// The back sequencer emits its events one at a time; some steps emit none. A close bracket
// first pops any prefix lists above it and emits their closes, then pops its own list in a
// silent step and emits its close; later prefix closes are emitted as the next list pops.
// Reset clears mode, stack level and token length; the stack memory is not cleared.
// A held event with m_tready low freezes the sequencer; the queue fills and s_tready drops.
module sexpr_reader_tokenizer_core import srt_pkg::*; #(
	parameter int STACK_DEPTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,   // [7:0] text_byte
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [2:0] event_res, [10:3] value,
	                                          // [13:11] error_code, [15:14] zero
	output logic                   m_tlast
);

	logic  fq_valid, fq_ready;
	item_t fq_item;
	logic  qb_valid, qb_ready;
	item_t qb_item;

	srt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_valid  (fq_valid),
		.q_ready  (fq_ready),
		.q_item   (fq_item)
	);

	srt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_item   (fq_item),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_item  (qb_item)
	);

	srt_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (qb_valid),
		.q_ready  (qb_ready),
		.q_item   (qb_item),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

[rtl/core/srt_ram.sv]
// Generic single-port-write RAM with registered read.
module srt_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/core/srt_front.sv]
// Front end: accepts text bytes and registers their classification.
module srt_front import srt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] text_byte
	output logic       q_valid,
	input  logic       q_ready,
	output item_t      q_item
);

	logic  valid_s1;
	item_t item_s1;

	assign s_tready = !valid_s1 || q_ready;
	assign q_valid  = valid_s1;
	assign q_item   = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= classify(s_tdata);
		end
	end

endmodule

[rtl/core/srt_queue.sv]
// Two-entry queue of classified items between front and back end.
module srt_queue import srt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  out_valid,
	input  logic  out_ready,
	output item_t out_item
);

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       wr;
	logic       rd;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_item  = slot_q[rd_ptr_q];
	assign wr        = in_valid && in_ready;
	assign rd        = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (wr && !rd) begin
				count_q <= count_q + 2'd1;
			end else if (rd && !wr) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

endmodule

[rtl/core/srt_back.sv]
// Back end: lexer mode, bracket stack and event sequencer with output register.
module srt_back import srt_pkg::*; #(
	parameter int STACK_DEPTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	output logic                   q_ready,
	input  item_t                  q_item,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tlast
);

	localparam int LW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	seq_t       st_q, st_d;
	mode_t      mode_q, mode_d;
	after_t     after_q, after_d, tail_aft;
	logic [2:0] pk_q, pk_d;
	logic [LW-1:0] level_q;
	logic [1:0] len_q;
	logic [1:0] head_q [0:2];
	logic [2:0] top_q;
	logic       stale_q;
	logic [2:0] rd_data;
	logic [2:0] top;
	logic [AW-1:0] rd_addr;

	logic       m_tvalid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic       out_last_q;

	logic       go;
	logic       ev_valid, ev_last;
	logic [2:0] ev_code, ev_err;
	logic [7:0] ev_value;
	logic       q_pop, push, pop_stk, restart, rec_sym, new_sym, clr_len, tok_end;
	logic       is_sym, pfx_top, is_num, ends_tok;
	logic [1:0] h0, h1, h2;
	logic [2:0] tok_code;
	mode_t      tok_mode;

	assign go  = !m_tvalid_q || m_tready;
	assign top = stale_q ? rd_data : top_q;

	// read the entry below the top so a pop can refill the cached top
	assign rd_addr = (level_q >= LW'(2)) ? AW'(level_q - LW'(2)) : '0;

	srt_ram #(
		.WIDTH (3),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk     (clk),
		.wr_en   (go && push),
		.wr_addr (level_q[AW-1:0]),
		.wr_data (q_item.kind),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign h0 = (len_q > 2'd0) ? head_q[0] : HC_OTHER;
	assign h1 = (len_q > 2'd1) ? head_q[1] : HC_OTHER;
	assign h2 = (len_q > 2'd2) ? head_q[2] : HC_OTHER;
	assign is_num = (h0 == HC_DIGIT) ||
	                (h0 == HC_DOT && h1 == HC_DIGIT) ||
	                (h0 == HC_SIGN && (h1 == HC_DIGIT || (h1 == HC_DOT && h2 == HC_DIGIT)));

	assign is_sym   = (mode_q == MODE_SYMBOL);
	assign pfx_top  = (level_q != '0) && (top >= K_QUOTE);
	assign tok_code = is_sym ? (is_num ? EV_NUM : EV_SYM) : EV_STR;
	assign ends_tok = is_sym && (q_item.cls == CLS_SEMI || q_item.cls == CLS_DQUOTE ||
	                             q_item.cls == CLS_OPEN || q_item.cls == CLS_CLOSE ||
	                             q_item.cls == CLS_SEP);

	always_comb begin
		case (q_item.cls)
			CLS_SEMI:   tok_mode = MODE_COMMENT;
			CLS_DQUOTE: tok_mode = MODE_STRING;
			default:    tok_mode = MODE_SPACE;
		endcase
	end

	always_comb begin
		ev_valid = 1'b0;
		ev_code  = EV_BYTE;
		ev_value = '0;
		ev_err   = ERR_NONE;
		ev_last  = 1'b0;
		q_pop    = 1'b0;
		push     = 1'b0;
		pop_stk  = 1'b0;
		restart  = 1'b0;
		rec_sym  = 1'b0;
		new_sym  = 1'b0;
		clr_len  = 1'b0;
		tok_end  = 1'b0;
		tail_aft = AFT_NONE;
		st_d     = st_q;
		mode_d   = mode_q;
		after_d  = after_q;
		pk_d     = pk_q;

		unique case (st_q)
			ST_DISPATCH: begin
				if (q_valid) begin
					if (q_item.cls == CLS_END) begin
						if (mode_q != MODE_ERROR && (level_q != '0 ||
						    mode_q == MODE_STRING || mode_q == MODE_ESCAPE)) begin
							ev_valid = 1'b1;
							ev_code  = EV_ERR;
							ev_err   = ERR_OPEN_AT_END;
							st_d     = ST_END;
						end else if (mode_q == MODE_SYMBOL) begin
							ev_valid = 1'b1;
							ev_code  = tok_code;
							st_d     = ST_END;
						end else begin
							ev_valid = 1'b1;
							ev_code  = EV_END;
							ev_last  = 1'b1;
							restart  = 1'b1;
							q_pop    = 1'b1;
						end
					end else begin
						unique case (mode_q)
							MODE_ERROR: q_pop = 1'b1;
							MODE_COMMENT: begin
								if (q_item.nl) begin
									mode_d = MODE_SPACE;
								end
								q_pop = 1'b1;
							end
							MODE_ESCAPE: begin
								ev_valid = 1'b1;
								ev_value = q_item.text_byte;
								ev_last  = 1'b1;
								mode_d   = MODE_STRING;
								q_pop    = 1'b1;
							end
							MODE_STRING: begin
								if (q_item.cls == CLS_DQUOTE) begin
									ev_valid = 1'b1;
									ev_code  = EV_STR;
									mode_d   = MODE_SPACE;
									tok_end  = 1'b1;
								end else if (q_item.cls == CLS_BSLASH) begin
									mode_d = MODE_ESCAPE;
									q_pop  = 1'b1;
								end else begin
									ev_valid = 1'b1;
									ev_value = q_item.text_byte;
									ev_last  = 1'b1;
									q_pop    = 1'b1;
								end
							end
							MODE_SPACE, MODE_SYMBOL: begin
								if (ends_tok) begin
									ev_valid = 1'b1;
									ev_code  = tok_code;
									mode_d   = tok_mode;
									clr_len  = (q_item.cls == CLS_DQUOTE);
									tok_end  = 1'b1;
									if (q_item.cls == CLS_OPEN) begin
										tail_aft = AFT_OPEN;
									end else if (q_item.cls == CLS_CLOSE) begin
										tail_aft = AFT_CLOSE;
									end
								end else begin
									case (q_item.cls)
										CLS_SEMI: begin
											mode_d = MODE_COMMENT;
											q_pop  = 1'b1;
										end
										CLS_DQUOTE: begin
											mode_d  = MODE_STRING;
											clr_len = 1'b1;
											q_pop   = 1'b1;
										end
										CLS_SEP:   q_pop = 1'b1;
										CLS_OPEN:  st_d = ST_OPEN;
										CLS_CLOSE: st_d = ST_CLOSE;
										default: begin
											ev_valid = 1'b1;
											ev_value = q_item.text_byte;
											ev_last  = 1'b1;
											rec_sym  = 1'b1;
											new_sym  = !is_sym;
											mode_d   = MODE_SYMBOL;
											q_pop    = 1'b1;
										end
									endcase
								end
							end
							default: q_pop = 1'b1;
						endcase
					end
				end
			end
			ST_OPEN: begin
				ev_valid = 1'b1;
				ev_last  = 1'b1;
				q_pop    = 1'b1;
				st_d     = ST_DISPATCH;
				if (level_q >= LW'(STACK_DEPTH)) begin
					ev_code = EV_ERR;
					ev_err  = ERR_OVERFLOW;
					mode_d  = MODE_ERROR;
				end else begin
					push     = 1'b1;
					ev_code  = EV_OPEN;
					ev_value = {5'd0, q_item.kind};
				end
			end
			ST_CLOSE: begin
				if (pfx_top) begin
					pop_stk = 1'b1;
					pk_d    = top;
					after_d = AFT_CLOSE;
					st_d    = ST_PFX;
				end else if (level_q == '0 || top != q_item.kind) begin
					ev_valid = 1'b1;
					ev_code  = EV_ERR;
					ev_err   = (level_q == '0) ? ERR_UNMATCHED : ERR_MISMATCH;
					ev_last  = 1'b1;
					mode_d   = MODE_ERROR;
					q_pop    = 1'b1;
					st_d     = ST_DISPATCH;
				end else begin
					pop_stk = 1'b1;
					pk_d    = q_item.kind;
					after_d = AFT_NONE;
					st_d    = ST_PFX;
				end
			end
			ST_PFX: begin
				// emit the popped close once the new top tells whether more follow
				ev_valid = 1'b1;
				ev_code  = EV_CLOSE;
				ev_value = {5'd0, pk_q};
				if (pfx_top) begin
					pop_stk = 1'b1;
					pk_d    = top;
				end else begin
					case (after_q)
						AFT_OPEN:  st_d = ST_OPEN;
						AFT_CLOSE: st_d = ST_CLOSE;
						default: begin
							ev_last = 1'b1;
							q_pop   = 1'b1;
							st_d    = ST_DISPATCH;
						end
					endcase
				end
			end
			ST_END: begin
				ev_valid = 1'b1;
				ev_code  = EV_END;
				ev_last  = 1'b1;
				restart  = 1'b1;
				q_pop    = 1'b1;
				st_d     = ST_DISPATCH;
			end
			default: st_d = ST_DISPATCH;
		endcase

		// after a token end: close pending prefix lists, then any bracket step
		if (tok_end) begin
			after_d = tail_aft;
			if (pfx_top) begin
				pop_stk = 1'b1;
				pk_d    = top;
				st_d    = ST_PFX;
			end else begin
				case (tail_aft)
					AFT_OPEN:  st_d = ST_OPEN;
					AFT_CLOSE: st_d = ST_CLOSE;
					default: begin
						ev_last = 1'b1;
						q_pop   = 1'b1;
					end
				endcase
			end
		end
	end

	assign q_ready = go && q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_DISPATCH;
			mode_q     <= MODE_SPACE;
			after_q    <= AFT_NONE;
			pk_q       <= K_PAREN;
			level_q    <= '0;
			len_q      <= 2'd0;
			stale_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (go) begin
				st_q       <= st_d;
				mode_q     <= restart ? MODE_SPACE : mode_d;
				after_q    <= after_d;
				pk_q       <= pk_d;
				m_tvalid_q <= ev_valid;
				if (restart || clr_len) begin
					len_q <= 2'd0;
				end else if (rec_sym) begin
					if (new_sym) begin
						len_q <= 2'd1;
					end else if (len_q != 2'd3) begin
						len_q <= len_q + 2'd1;
					end
				end
				if (restart) begin
					level_q <= '0;
				end else if (push) begin
					level_q <= level_q + LW'(1);
				end else if (pop_stk) begin
					level_q <= level_q - LW'(1);
				end
			end
			if (go && push) begin
				stale_q <= 1'b0;
			end else if (go && pop_stk) begin
				stale_q <= 1'b1;
			end else begin
				stale_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && push) begin
			top_q <= q_item.kind;
		end else if (!(go && pop_stk) && stale_q) begin
			// capture the refilled top before the read address moves on
			top_q <= rd_data;
		end
		if (go && rec_sym) begin
			if (new_sym) begin
				head_q[0] <= q_item.hc;
			end else if (len_q != 2'd3) begin
				head_q[len_q] <= q_item.hc;
			end
		end
		if (go && ev_valid) begin
			out_data_q <= {2'b00, ev_err, ev_value, ev_code};
			out_last_q <= ev_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LW'(STACK_DEPTH))
		else $error("bracket stack level past depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		go && pop_stk |-> level_q != '0)
		else $error("pop from empty bracket stack");

	a_item_held: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != ST_DISPATCH |-> q_valid)
		else $error("sequencer lost its item mid-sequence");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && out_data_q[2:0] == EV_END |-> out_last_q)
		else $error("text end transfer not marked last");

	a_error_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		go && ev_valid && mode_q == MODE_ERROR |-> ev_code == EV_END)
		else $error("event emitted while dropping after error");

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for the S-expression tokenizer core: random text in, reader events checked.
module tb_top;
	import srt_pkg::*;

	localparam int DEPTH      = 32;
	localparam int RANDOM_FED = 270;
	localparam int RUN_LIMIT  = 400000;
	localparam int TAIL_WAIT  = 64;
	localparam int HOLD_LEN   = 300;
	localparam logic [7:0] CH_A = "a";
	localparam logic [7:0] CH_Z = "z";

	typedef enum logic [1:0] {IDLE_RX_HEAVY, IDLE_TX_HEAVY, IDLE_NONE} idle_plan_t;

	typedef struct packed {
		logic [2:0] ev;
		logic [7:0] val;
		logic [2:0] err;
		logic       last;
	} reader_event_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [7:0]             s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;

	// bit 8 set: hold this byte until every event due has arrived
	logic [8:0]    text_bytes[$];
	logic [7:0]    draft_text[$];
	reader_event_t events_due[$];
	reader_event_t burst[$];

	// tokenizer state as the text so far leaves it
	mode_t       lex_mode = MODE_SPACE;
	logic [2:0]  kind_stack[DEPTH];
	int unsigned stack_lvl = 0;
	logic [7:0]  tok_head[3];
	int unsigned head_len = 0;

	int    total_items = 0;
	int    in_count = 0;
	int    out_count = 0;
	int    bad_count = 0;
	int    cycles = 0;
	int    rx_hold_left = 0;
	bit    rx_hold_done = 1'b0;
	bit    byte_taken = 1'b0;
	string sym_punct = "+-.*!?<>=_/&%$#@^|:\\";

	sexpr_reader_tokenizer_core #(
		.STACK_DEPTH(DEPTH)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------- prediction

	task automatic emit_event(input logic [2:0] ev, input logic [7:0] val,
			input logic [2:0] err);
		reader_event_t e;
		e.ev   = ev;
		e.val  = val;
		e.err  = err;
		e.last = 1'b0;
		burst.push_back(e);
	endtask

	task automatic raise_error(input logic [2:0] code);
		emit_event(EV_ERR, 8'd0, code);
		lex_mode = MODE_ERROR;
	endtask

	function automatic logic is_digit(input logic [7:0] b);
		return b >= CH_0 && b <= CH_9;
	endfunction

	function automatic logic [7:0] head_byte(input int unsigned i);
		return (i < head_len && i < 3) ? tok_head[i] : CH_NUL;
	endfunction

	task automatic pop_prefixes();
		while (stack_lvl > 0 && kind_stack[stack_lvl - 1] >= K_QUOTE) begin
			stack_lvl--;
			emit_event(EV_CLOSE, {5'd0, kind_stack[stack_lvl]}, ERR_NONE);
		end
	endtask

	task automatic end_token();
		logic [7:0] b0, b1, b2;
		logic       num;
		if (lex_mode == MODE_SYMBOL) begin
			b0 = head_byte(0);
			b1 = head_byte(1);
			b2 = head_byte(2);
			num = is_digit(b0) || (b0 == CH_DOT && is_digit(b1)) ||
				((b0 == CH_MINUS || b0 == CH_PLUS) &&
				(is_digit(b1) || (b1 == CH_DOT && is_digit(b2))));
			emit_event(num ? EV_NUM : EV_SYM, 8'd0, ERR_NONE);
		end else begin
			emit_event(EV_STR, 8'd0, ERR_NONE);
		end
		lex_mode = MODE_SPACE;
		pop_prefixes();
	endtask

	task automatic push_list(input logic [2:0] k);
		if (stack_lvl >= DEPTH) begin
			raise_error(ERR_OVERFLOW);
		end else begin
			kind_stack[stack_lvl] = k;
			stack_lvl++;
			emit_event(EV_OPEN, {5'd0, k}, ERR_NONE);
		end
	endtask

	task automatic pop_list(input logic [2:0] k);
		pop_prefixes();
		if (stack_lvl == 0) begin
			raise_error(ERR_UNMATCHED);
		end else if (kind_stack[stack_lvl - 1] != k) begin
			raise_error(ERR_MISMATCH);
		end else begin
			stack_lvl--;
			emit_event(EV_CLOSE, {5'd0, k}, ERR_NONE);
			pop_prefixes();
		end
	endtask

	task automatic tokenize_byte(input logic [7:0] b);
		logic          sym, is_open, is_close;
		logic [2:0]    k;
		reader_event_t e;
		burst.delete();
		if (b == CH_NUL) begin
			if (lex_mode != MODE_ERROR) begin
				if (stack_lvl > 0 || lex_mode == MODE_STRING || lex_mode == MODE_ESCAPE)
					raise_error(ERR_OPEN_AT_END);
				else if (lex_mode == MODE_SYMBOL)
					end_token();
			end
			emit_event(EV_END, 8'd0, ERR_NONE);
			lex_mode = MODE_SPACE;
			stack_lvl = 0;
			head_len = 0;
		end else if (lex_mode == MODE_ERROR) begin
			// drop until the end byte
		end else if (lex_mode == MODE_COMMENT) begin
			if (b == CH_LF || b == CH_CR)
				lex_mode = MODE_SPACE;
		end else if (lex_mode == MODE_ESCAPE) begin
			emit_event(EV_BYTE, b, ERR_NONE);
			lex_mode = MODE_STRING;
		end else if (lex_mode == MODE_STRING) begin
			if (b == CH_DQUOTE)
				end_token();
			else if (b == CH_BSLASH)
				lex_mode = MODE_ESCAPE;
			else
				emit_event(EV_BYTE, b, ERR_NONE);
		end else begin
			sym = (lex_mode == MODE_SYMBOL);
			is_open = 1'b0;
			is_close = 1'b0;
			k = K_PAREN;
			case (b)
				CH_LPAREN: begin is_open = 1'b1; k = K_PAREN; end
				CH_LBRACK: begin is_open = 1'b1; k = K_VECTOR; end
				CH_LBRACE: begin is_open = 1'b1; k = K_MAP; end
				CH_SQUOTE: begin is_open = 1'b1; k = K_QUOTE; end
				CH_BTICK: begin is_open = 1'b1; k = K_QUASI; end
				CH_TILDE: begin is_open = 1'b1; k = K_UNQUOTE; end
				CH_RPAREN: begin is_close = 1'b1; k = K_PAREN; end
				CH_RBRACK: begin is_close = 1'b1; k = K_VECTOR; end
				CH_RBRACE: begin is_close = 1'b1; k = K_MAP; end
				default: ;
			endcase
			if (b == CH_SEMI) begin
				if (sym) end_token();
				lex_mode = MODE_COMMENT;
			end else if (b == CH_DQUOTE) begin
				if (sym) end_token();
				lex_mode = MODE_STRING;
				head_len = 0;
			end else if (is_open) begin
				if (sym) end_token();
				push_list(k);
			end else if (is_close) begin
				if (sym) end_token();
				pop_list(k);
			end else if (b == CH_COMMA || b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) begin
				if (sym) end_token();
			end else begin
				if (!sym) begin
					lex_mode = MODE_SYMBOL;
					head_len = 0;
				end
				if (head_len < 3) begin
					tok_head[head_len] = b;
					head_len++;
				end
				emit_event(EV_BYTE, b, ERR_NONE);
			end
		end
		foreach (burst[i]) begin
			e = burst[i];
			e.last = (i == burst.size() - 1);
			events_due.push_back(e);
		end
	endtask

	// ---------------------------------------------------------------- text generation

	function automatic logic [7:0] open_byte(input logic [2:0] k);
		case (k)
			K_PAREN:  return CH_LPAREN;
			K_VECTOR: return CH_LBRACK;
			K_MAP:    return CH_LBRACE;
			K_QUOTE:  return CH_SQUOTE;
			K_QUASI:  return CH_BTICK;
			default:  return CH_TILDE;
		endcase
	endfunction

	function automatic logic [7:0] close_byte(input logic [2:0] k);
		case (k)
			K_PAREN:  return CH_RPAREN;
			K_VECTOR: return CH_RBRACK;
			default:  return CH_RBRACE;
		endcase
	endfunction

	function automatic logic [7:0] sym_char();
		case ($urandom_range(3, 0))
			0:       return 8'(CH_A + $urandom_range(25, 0));
			1:       return 8'(CH_0 + $urandom_range(9, 0));
			2:       return sym_punct[$urandom_range(sym_punct.len() - 1, 0)];
			default: return 8'($urandom_range(255, 128));
		endcase
	endfunction

	task automatic put_byte(input logic [7:0] b);
		draft_text.push_back(b);
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++)
			draft_text.push_back(s[i]);
	endtask

	task automatic gen_gap();
		int         n;
		logic [7:0] b;
		if ($urandom_range(7, 0) == 0) begin
			n = $urandom_range(6, 0);
			put_byte(CH_SEMI);
			repeat (n) begin
				b = 8'($urandom_range(255, 1));
				put_byte((b == CH_LF || b == CH_CR) ? CH_Z : b);
			end
			put_byte($urandom_range(1, 0) ? CH_LF : CH_CR);
		end else begin
			repeat ($urandom_range(2, 1)) begin
				case ($urandom_range(2, 0))
					0:       put_byte(CH_SPACE);
					1:       put_byte(CH_COMMA);
					default: put_byte(8'($urandom_range(CH_CR, CH_TAB)));
				endcase
			end
		end
	endtask

	task automatic gen_symbol();
		if ($urandom_range(1, 0)) begin
			// number-like heads reach every branch of the number test
			case ($urandom_range(3, 0))
				0:       put_byte(8'(CH_0 + $urandom_range(9, 0)));
				1:       put_byte(CH_DOT);
				2:       put_byte(CH_PLUS);
				default: put_byte(CH_MINUS);
			endcase
			repeat ($urandom_range(3, 0)) begin
				case ($urandom_range(2, 0))
					0:       put_byte(8'(CH_0 + $urandom_range(9, 0)));
					1:       put_byte(CH_DOT);
					default: put_byte(8'(CH_A + $urandom_range(25, 0)));
				endcase
			end
		end else begin
			repeat ($urandom_range(5, 1))
				put_byte(sym_char());
		end
	endtask

	task automatic gen_string();
		logic [7:0] b;
		put_byte(CH_DQUOTE);
		repeat ($urandom_range(5, 0)) begin
			if ($urandom_range(4, 0) == 0) begin
				put_byte(CH_BSLASH);
				put_byte(8'($urandom_range(255, 1)));
			end else begin
				b = 8'($urandom_range(255, 1));
				put_byte((b == CH_DQUOTE || b == CH_BSLASH) ? CH_Z : b);
			end
		end
		put_byte(CH_DQUOTE);
	endtask

	task automatic gen_form(input int lvl);
		int         r;
		logic [2:0] k;
		r = (lvl >= 3) ? $urandom_range(3, 0) : $urandom_range(9, 0);
		if (r <= 2) begin
			gen_symbol();
		end else if (r == 3) begin
			gen_string();
		end else if (r <= 6) begin
			k = 3'($urandom_range(2, 0));
			put_byte(open_byte(k));
			if ($urandom_range(3, 0) == 0) gen_gap();
			for (int i = 0; i < $urandom_range(3, 0); i++) begin
				if (i > 0) gen_gap();
				gen_form(lvl + 1);
			end
			if ($urandom_range(3, 0) == 0) gen_gap();
			put_byte(close_byte(k));
		end else begin
			put_byte(open_byte(3'($urandom_range(5, 3))));
			if ($urandom_range(3, 0) == 0) gen_gap();
			gen_form(lvl + 1);
		end
	endtask

	task automatic gen_text();
		int n;
		n = $urandom_range(3, 1);
		for (int i = 0; i < n; i++) begin
			if (i > 0) gen_gap();
			gen_form(0);
		end
		if ($urandom_range(1, 0)) gen_gap();
	endtask

	// cut the text short, slip in a stray close, or change the kind of a close
	task automatic break_text();
		int n, pos;
		int spots[$];
		n = draft_text.size();
		case ($urandom_range(2, 0))
			0: begin
				pos = $urandom_range(n - 1, 0);
				while (draft_text.size() > pos)
					void'(draft_text.pop_back());
			end
			1: draft_text.insert($urandom_range(n, 0), close_byte(3'($urandom_range(2, 0))));
			default: begin
				foreach (draft_text[i])
					if (draft_text[i] == CH_RPAREN || draft_text[i] == CH_RBRACK ||
							draft_text[i] == CH_RBRACE)
						spots.push_back(i);
				if (spots.size() > 0)
					draft_text[spots[$urandom_range(spots.size() - 1, 0)]] =
						close_byte(3'($urandom_range(2, 0)));
				else
					draft_text.insert($urandom_range(n, 0),
						close_byte(3'($urandom_range(2, 0))));
			end
		endcase
	endtask

	task automatic commit_text(input bit hold_first);
		foreach (draft_text[i])
			text_bytes.push_back({hold_first && (i == 0), draft_text[i]});
		draft_text.delete();
	endtask

	// ---------------------------------------------------------------- stimulus and end

	initial begin
		int r, nth, fed;

		// prefix closes after a bracketed list
		put_str("'(a)");
		put_byte(CH_NUL);
		commit_text(1'b0);
		// map, sign-dot-digit number, comment to LF, close with a pending prefix
		put_str("{+.5;c");
		put_byte(CH_LF);
		put_str("'}");
		put_byte(CH_NUL);
		commit_text(1'b0);
		// escaped top byte, symbol of a high byte, unmatched close
		put_str("\"\\");
		put_byte(8'hFF);
		put_str("\"");
		put_byte(8'h80);
		put_str(")");
		put_byte(CH_NUL);
		commit_text(1'b0);
		// mismatch
		put_str("[)");
		put_byte(CH_NUL);
		commit_text(1'b0);
		// end inside open prefix lists
		put_str("`~");
		put_byte(CH_NUL);
		commit_text(1'b0);
		// sign-dot-digit number, comma, symbol ended by a string, end inside string
		put_str("-.7,x\"y");
		put_byte(CH_NUL);
		commit_text(1'b0);

		fed = text_bytes.size();
		nth = 0;
		while (fed < RANDOM_FED) begin
			r = $urandom_range(99, 0);
			if (r < 66) begin
				gen_text();
			end else if (r < 80) begin
				gen_text();
				break_text();
			end else if (r < 88) begin
				repeat ($urandom_range(20, 1))
					put_byte(8'($urandom_range(255, 1)));
			end else if (r < 94) begin
				// one bracket under a long prefix chain: many closes from one byte
				put_byte(CH_LPAREN);
				repeat ($urandom_range(DEPTH - 1, DEPTH - 12))
					put_byte(open_byte(3'($urandom_range(5, 3))));
				gen_symbol();
				put_byte(CH_RPAREN);
			end else begin
				repeat (DEPTH + 1)
					put_byte(open_byte(3'($urandom_range(5, 0))));
			end
			put_byte(CH_NUL);
			fed += draft_text.size();
			commit_text(nth == 4 || $urandom_range(11, 0) == 0);
			nth++;
		end
		total_items = text_bytes.size();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (in_count != total_items) @(posedge clk);
		while (events_due.size() != 0) @(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
		if (bad_count == 0 && events_due.size() == 0)
			$display("** sexpr_reader_tokenizer_core: PASSED **");
		else
			$display("** sexpr_reader_tokenizer_core: FAILED **");
		$finish;
	end

	function automatic idle_plan_t idle_plan();
		if (in_count < total_items / 3)
			return IDLE_RX_HEAVY;
		else if (in_count < 2 * total_items / 3)
			return IDLE_TX_HEAVY;
		return IDLE_NONE;
	endfunction

	// ---------------------------------------------------------------- driver

	always @(negedge clk) begin
		logic idle;
		if (arst_n && (!s_tvalid || byte_taken)) begin
			byte_taken = 1'b0;
			case (idle_plan())
				IDLE_RX_HEAVY: idle = $urandom_range(99, 0) < 35;
				IDLE_TX_HEAVY: idle = $urandom_range(99, 0) < 69;
				default:       idle = 1'b0;
			endcase
			// keep offering while the sink holds off, so the block backs up
			if (rx_hold_left > 0)
				idle = 1'b0;
			if (text_bytes.size() > 0 && text_bytes[0][8] && events_due.size() > 0) begin
				s_tvalid <= 1'b0;
			end else if (text_bytes.size() > 0 && !idle) begin
				s_tvalid <= 1'b1;
				s_tdata  <= text_bytes[0][7:0];
				void'(text_bytes.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!rx_hold_done && in_count >= total_items / 6) begin
				rx_hold_done = 1'b1;
				rx_hold_left = HOLD_LEN;
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (idle_plan())
					IDLE_RX_HEAVY: m_tready <= $urandom_range(99, 0) >= 69;
					IDLE_TX_HEAVY: m_tready <= $urandom_range(99, 0) >= 35;
					default:       m_tready <= 1'b1;
				endcase
			end
		end
	end

	// ---------------------------------------------------------------- monitors

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			tokenize_byte(s_tdata);
			in_count++;
			byte_taken = 1'b1;
		end
	end

	always @(posedge clk) begin
		reader_event_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got.ev   = m_tdata[2:0];
			got.val  = m_tdata[10:3];
			got.err  = m_tdata[13:11];
			got.last = m_tlast;
			if (events_due.size() == 0) begin
				if (bad_count < 10)
					$display("event %0d arrived with none due: ev %0d val %02h err %0d last %0b",
						out_count, got.ev, got.val, got.err, got.last);
				bad_count++;
			end else begin
				want = events_due.pop_front();
				if (got.ev != want.ev || got.val != want.val || got.err != want.err ||
						got.last != want.last) begin
					if (bad_count < 10)
						$display("event %0d (exp/got): ev %0d/%0d val %02h/%02h err %0d/%0d last %0b/%0b",
							out_count, want.ev, got.ev, want.val, got.val, want.err, got.err,
							want.last, got.last);
					bad_count++;
				end
			end
			out_count++;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == RUN_LIMIT) begin
			$display("** sexpr_reader_tokenizer_core: FAILED **");
			$finish;
		end
	end

endmodule
